// ----- hdl/pdf_pkg.sv -----
`timescale 1ns / 1ps
// Package for the projectile drag force pipeline: payload structs,
// fixed-point constants and the elaboration-time pressure factor function.
// No dependencies.
package pdf_pkg;

    // Field widths of the input and result items.
    localparam int SPEED_W = 15;
    localparam int ALT_W   = 15;
    localparam int DIAM_W  = 10;
    localparam int SCALE_W = 16;
    localparam int FORCE_W = 40;

    // Internal value widths.
    localparam int T2_W   = 20;   // temperature in 0.5 mK units
    localparam int Q30_W  = 30;   // pressure factors, all below one
    localparam int E_W    = 31;   // pressure ratio in Q30, up to one
    localparam int RHO_W  = 32;   // density in Q30
    localparam int ROOT_W = 26;   // square root of the temperature term
    localparam int C_W    = 25;   // speed of sound in Q16
    localparam int MACH_W = 20;   // Mach number in Q16
    localparam int CD_W   = 16;   // drag coefficient in Q16

    // Atmosphere constants.
    localparam logic [ALT_W-1:0] ALT_LIMIT = 15'd20000;
    localparam logic [T2_W-1:0]  T2_SEA    = 20'd576300;
    localparam logic [T2_W-1:0]  T2_LAPSE  = 20'd13;
    localparam logic [E_W-1:0]   E_ONE     = 31'd1073741824;
    localparam logic [Q30_W-1:0] Q30_HALF  = 30'd536870912;
    localparam logic [19:0]      RHO_K     = 20'd705954;
    localparam logic [14:0]      SOUND_K   = 15'd29376;
    localparam logic [21:0]      AREA_K    = 22'd3454217;

    // Mach band limits of the drag law.
    localparam logic [MACH_W-1:0] MACH_B1 = 20'd52429;
    localparam logic [MACH_W-1:0] MACH_B2 = 20'd58982;
    localparam logic [MACH_W-1:0] MACH_B3 = 20'd65536;
    localparam logic [MACH_W-1:0] MACH_B4 = 20'd91750;
    localparam logic [MACH_W-1:0] MACH_B5 = 20'd262144;

    // Band polynomial coefficients and offsets.
    localparam logic [13:0] CD2_M2 = 14'd8978;
    localparam logic [12:0] CD2_M  = 13'd5669;
    localparam logic [16:0] CD3_M  = 17'd88474;
    localparam logic [17:0] CD4_M  = 18'd153027;
    localparam logic [15:0] CD4_M2 = 16'd60621;
    localparam logic [12:0] CD5_M  = 13'd6010;
    localparam logic signed [35:0] CD1_VAL = 36'sd10355;
    localparam logic signed [35:0] CD2_OFS = 36'sd59;
    localparam logic signed [35:0] CD3_OFS = 36'sd67174;
    localparam logic signed [35:0] CD4_OFS = 36'sd71107;
    localparam logic signed [35:0] CD5_OFS = 36'sd32722;
    localparam logic signed [35:0] CD6_VAL = 36'sd8684;

    // Input item.
    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [ALT_W-1:0]   altitude;
        logic [DIAM_W-1:0]  diameter_mm;
        logic [SCALE_W-1:0] drag_scale;
    } pdf_in_t;

    // Result item.
    typedef struct packed {
        logic [FORCE_W-1:0] drag_force;
        logic               saturated;
    } pdf_out_t;

    // Values carried alongside the pressure and density stages.
    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [DIAM_W-1:0]  diameter_mm;
        logic [SCALE_W-1:0] drag_scale;
        logic [T2_W-1:0]    t2;
    } pdf_side_a_t;

    // Values carried alongside the sound speed and Mach stages.
    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [DIAM_W-1:0]  diameter_mm;
        logic [SCALE_W-1:0] drag_scale;
        logic [RHO_W-1:0]   rho;
    } pdf_side_b_t;

    // Pressure factor exp(-2^idx/H) in Q30, squared up from the one-metre seed.
    function automatic logic [Q30_W-1:0] exp_factor(input int unsigned idx);
        logic [63:0] f;
        f = 64'd1073614487;
        for (int unsigned i = 0; i < idx; i++) begin
            f = (f * f + 64'd536870912) >> 30;
        end
        return f[Q30_W-1:0];
    endfunction

endpackage

// ----- hdl/pdf_exp_pipe.sv -----
`timescale 1ns / 1ps
// Pressure ratio pipeline: one stage per altitude bit multiplies in a fixed factor.
// Depends on pdf_pkg.
module pdf_exp_pipe #(
    parameter int SIDE_W = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       vld_i,
    input  logic [pdf_pkg::ALT_W-1:0]  h_i,
    input  logic [SIDE_W-1:0]          side_i,
    output logic                       vld_o,
    output logic [pdf_pkg::E_W-1:0]    e_o,
    output logic [SIDE_W-1:0]          side_o
);
    import pdf_pkg::*;

    logic             vld_reg  [ALT_W];
    logic [ALT_W-1:0] h_reg    [ALT_W];
    logic [E_W-1:0]   acc_reg  [ALT_W];
    logic [SIDE_W-1:0] side_reg [ALT_W];

    for (genvar g = 0; g < ALT_W; g++) begin : g_stage
        localparam logic [Q30_W-1:0] FACTOR = exp_factor(g);

        logic              vld_in;
        logic [ALT_W-1:0]  h_in;
        logic [E_W-1:0]    acc_in;
        logic [SIDE_W-1:0] side_in;
        logic [60:0]       prod;
        logic [61:0]       rnd;
        logic [E_W-1:0]    acc_next;

        if (g == 0) begin : g_first
            assign vld_in  = vld_i;
            assign h_in    = h_i;
            assign acc_in  = E_ONE;
            assign side_in = side_i;
        end else begin : g_next
            assign vld_in  = vld_reg[g-1];
            assign h_in    = h_reg[g-1];
            assign acc_in  = acc_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        // Multiply in this bit's factor and round back to Q30.
        assign prod     = 61'(acc_in) * 61'(FACTOR);
        assign rnd      = 62'(prod) + 62'(Q30_HALF);
        assign acc_next = h_in[g] ? rnd[60:30] : acc_in;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                h_reg[g]    <= h_in;
                acc_reg[g]  <= acc_next;
                side_reg[g] <= side_in;
            end
        end
    end

    assign vld_o  = vld_reg[ALT_W-1];
    assign e_o    = acc_reg[ALT_W-1];
    assign side_o = side_reg[ALT_W-1];

endmodule

// ----- hdl/pdf_div_pipe.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Depends on pdf_pkg only through the common file set; no package items used.
module pdf_div_pipe #(
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 8,
    parameter int QUO_W  = 4,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              vld_i,
    input  logic [NUM_W-1:0]  num_i,
    input  logic [DEN_W-1:0]  den_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic              vld_o,
    output logic [QUO_W-1:0]  quo_o,
    output logic [SIDE_W-1:0] side_o
);

    logic              vld_reg  [QUO_W];
    logic [DEN_W-1:0]  rem_reg  [QUO_W];
    logic [QUO_W-1:0]  lq_reg   [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        logic              vld_in;
        logic [DEN_W-1:0]  rem_in;
        logic [QUO_W-1:0]  lq_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;

        // The upper numerator bits seed the remainder; they are below the divisor.
        if (g == 0) begin : g_first
            assign vld_in  = vld_i;
            assign rem_in  = DEN_W'(num_i[NUM_W-1:QUO_W]);
            assign lq_in   = num_i[QUO_W-1:0];
            assign den_in  = den_i;
            assign side_in = side_i;
        end else begin : g_next
            assign vld_in  = vld_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign lq_in   = lq_reg[g-1];
            assign den_in  = den_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        // Bring down the next numerator bit and try to subtract the divisor.
        assign trial = {rem_in, lq_in[QUO_W-1]};
        assign ge    = trial >= {1'b0, den_in};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                lq_reg[g]   <= {lq_in[QUO_W-2:0], ge};
                den_reg[g]  <= den_in;
                side_reg[g] <= side_in;
            end
        end
    end

    assign vld_o  = vld_reg[QUO_W-1];
    assign quo_o  = lq_reg[QUO_W-1];
    assign side_o = side_reg[QUO_W-1];

endmodule

// ----- hdl/pdf_isqrt_pipe.sv -----
`timescale 1ns / 1ps
// Pipelined floor square root, one root bit per stage, with side data.
// Self-contained; no package items used.
module pdf_isqrt_pipe #(
    parameter int ROOT_W = 8,
    parameter int SIDE_W = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  vld_i,
    input  logic [2*ROOT_W-1:0]   x_i,
    input  logic [SIDE_W-1:0]     side_i,
    output logic                  vld_o,
    output logic [ROOT_W-1:0]     root_o,
    output logic [SIDE_W-1:0]     side_o
);

    localparam int X_W   = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic              vld_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [X_W-1:0]    xs_reg   [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic              vld_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [X_W-1:0]    xs_in;
        logic [SIDE_W-1:0] side_in;
        logic [REM_W-1:0]  cand;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (g == 0) begin : g_first
            assign vld_in  = vld_i;
            assign rem_in  = '0;
            assign root_in = '0;
            assign xs_in   = x_i;
            assign side_in = side_i;
        end else begin : g_next
            assign vld_in  = vld_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign xs_in   = xs_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        // Bring down two radicand bits and test the next root bit.
        assign cand  = {rem_in[REM_W-3:0], xs_in[X_W-1:X_W-2]};
        assign trial = REM_W'({root_in, 2'b01});
        assign ge    = cand >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= ge ? cand - trial : cand;
                root_reg[g] <= {root_in[ROOT_W-2:0], ge};
                xs_reg[g]   <= {xs_in[X_W-3:0], 2'b00};
                side_reg[g] <= side_in;
            end
        end
    end

    assign vld_o  = vld_reg[ROOT_W-1];
    assign root_o = root_reg[ROOT_W-1];
    assign side_o = side_reg[ROOT_W-1];

endmodule

// ----- hdl/pdf_drag_tail.sv -----
`timescale 1ns / 1ps
// Final ten stages: drag coefficient bands, dynamic pressure, area and force.
// Depends on pdf_pkg.
module pdf_drag_tail (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         vld_i,
    input  logic [pdf_pkg::MACH_W-1:0]   mach_i,
    input  pdf_pkg::pdf_side_b_t         side_i,
    output logic                         vld_o,
    output pdf_pkg::pdf_out_t            res_o
);
    import pdf_pkg::*;

    localparam int NSTG = 10;

    // Round to nearest and drop sixteen fraction bits.
    function automatic logic [32:0] rnd16(input logic [47:0] x);
        logic [48:0] s;
        s = 49'(x) + 49'd32768;
        return s[48:16];
    endfunction

    logic vld_reg [NSTG];

    logic [MACH_W-1:0]  mach1_reg, mach2_reg, mach3_reg;
    logic [39:0]        msq1_reg;
    logic [29:0]        ssq1_reg;
    logic [19:0]        dd1_reg;
    logic [RHO_W-1:0]   rho1_reg;
    logic [SCALE_W-1:0] k1_reg, k2_reg, k3_reg, k4_reg, k5_reg, k6_reg;
    logic [24:0]        msr2_reg;
    logic [61:0]        qraw2_reg;
    logic [41:0]        araw2_reg;
    logic [47:0]        t2a3_reg, t3a3_reg, t4a3_reg, t4b3_reg, t5a3_reg;
    logic [38:0]        q3_reg, q4_reg;
    logic [31:0]        area3_reg, area4_reg, area5_reg, area6_reg, area7_reg, area8_reg;
    logic [CD_W-1:0]    cd4_reg;
    logic [54:0]        qcraw5_reg;
    logic [38:0]        qc6_reg;
    logic [54:0]        qkraw7_reg;
    logic [46:0]        qk8_reg;
    logic [62:0]        plo9_reg, phi9_reg;
    pdf_out_t           out_reg;

    logic [40:0]        msq_rnd;
    logic [62:0]        q_rnd;
    logic [42:0]        area_rnd;
    logic signed [35:0] b2, b3, b4, b5, cd_s;
    logic [CD_W-1:0]    cd_next;
    logic [55:0]        qc_rnd;
    logic [55:0]        qk_rnd;
    logic [63:0]        lo_rnd;
    logic [64:0]        sum;
    logic [40:0]        frc;

    // Valid bits move with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSTG; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= vld_i;
            for (int i = 1; i < NSTG; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Rounding of the wide products.
    assign msq_rnd  = 41'(msq1_reg) + 41'd32768;
    assign q_rnd    = 63'(qraw2_reg) + (63'd1 << 22);
    assign area_rnd = 43'(araw2_reg) + 43'd512;
    assign qc_rnd   = 56'(qcraw5_reg) + 56'd32768;
    assign qk_rnd   = 56'(qkraw7_reg) + 56'd128;

    // Drag coefficient for each Mach band; a negative value becomes zero.
    always_comb begin
        b2 = $signed(36'(rnd16(t2a3_reg))) + CD2_OFS;
        b3 = $signed(36'(rnd16(t3a3_reg))) - CD3_OFS;
        b4 = $signed(36'(rnd16(t4a3_reg))) - $signed(36'(rnd16(t4b3_reg))) - CD4_OFS;
        b5 = CD5_OFS - $signed(36'(rnd16(t5a3_reg)));
        if (mach3_reg <= MACH_B1) begin
            cd_s = CD1_VAL;
        end else if (mach3_reg <= MACH_B2) begin
            cd_s = b2;
        end else if (mach3_reg <= MACH_B3) begin
            cd_s = b3;
        end else if (mach3_reg <= MACH_B4) begin
            cd_s = b4;
        end else if (mach3_reg <= MACH_B5) begin
            cd_s = b5;
        end else begin
            cd_s = CD6_VAL;
        end
        cd_next = (cd_s < 0) ? '0 : cd_s[CD_W-1:0];
    end

    // Force assembly from the split area and saturation check.
    assign lo_rnd = 64'(plo9_reg) + (64'd1 << 39);
    assign sum    = 65'(phi9_reg) + 65'(lo_rnd[63:16]);
    assign frc    = sum[64:24];

    // Pipeline registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            // Squares of Mach, speed and diameter.
            mach1_reg <= mach_i;
            msq1_reg  <= 40'(mach_i) * 40'(mach_i);
            ssq1_reg  <= 30'(side_i.speed) * 30'(side_i.speed);
            dd1_reg   <= 20'(side_i.diameter_mm) * 20'(side_i.diameter_mm);
            rho1_reg  <= side_i.rho;
            k1_reg    <= side_i.drag_scale;

            // Rounded Mach square, raw dynamic pressure and raw area.
            mach2_reg <= mach1_reg;
            msr2_reg  <= msq_rnd[40:16];
            qraw2_reg <= 62'(rho1_reg) * 62'(ssq1_reg);
            araw2_reg <= 42'(dd1_reg) * 42'(AREA_K);
            k2_reg    <= k1_reg;

            // Band polynomial terms.
            mach3_reg <= mach2_reg;
            t2a3_reg  <= 48'(CD2_M2) * 48'(msr2_reg) + 48'(CD2_M) * 48'(mach2_reg);
            t3a3_reg  <= 48'(CD3_M) * 48'(mach2_reg);
            t4a3_reg  <= 48'(CD4_M) * 48'(mach2_reg);
            t4b3_reg  <= 48'(CD4_M2) * 48'(msr2_reg);
            t5a3_reg  <= 48'(CD5_M) * 48'(mach2_reg);
            q3_reg    <= q_rnd[61:23];
            area3_reg <= area_rnd[41:10];
            k3_reg    <= k2_reg;

            // Band selection.
            cd4_reg   <= cd_next;
            q4_reg    <= q3_reg;
            area4_reg <= area3_reg;
            k4_reg    <= k3_reg;

            // Pressure times coefficient.
            qcraw5_reg <= 55'(q4_reg) * 55'(cd4_reg);
            area5_reg  <= area4_reg;
            k5_reg     <= k4_reg;

            qc6_reg   <= qc_rnd[54:16];
            area6_reg <= area5_reg;
            k6_reg    <= k5_reg;

            // Scale by the user multiplier.
            qkraw7_reg <= 55'(qc6_reg) * 55'(k6_reg);
            area7_reg  <= area6_reg;

            qk8_reg   <= qk_rnd[54:8];
            area8_reg <= area7_reg;

            // Area applied in two sixteen-bit halves.
            plo9_reg <= 63'(qk8_reg) * 63'(area8_reg[15:0]);
            phi9_reg <= 63'(qk8_reg) * 63'(area8_reg[31:16]);

            // Output register with clamping.
            if (frc[40]) begin
                out_reg.drag_force <= '1;
                out_reg.saturated  <= 1'b1;
            end else begin
                out_reg.drag_force <= frc[FORCE_W-1:0];
                out_reg.saturated  <= 1'b0;
            end
        end
    end

    assign vld_o = vld_reg[NSTG-1];
    assign res_o = out_reg;

endmodule

// ----- hdl/projectile_drag_force.sv -----
`timescale 1ns / 1ps
// Projectile drag force pipeline. Its stages, from input to result:
// 15 pressure stages, 1 density product, 32 density divider stages,
// 26 square root stages, 1 sound speed product, 20 Mach divider stages, 10 tail.
// Throughput is one item per cycle; the whole pipeline holds while a result waits.
// Reset (aresetn low, synchronous) clears all valid bits; data registers keep values.
module projectile_drag_force (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pdf_pkg::pdf_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pdf_pkg::pdf_out_t  m_data
);
    import pdf_pkg::*;

    localparam int SA_W = $bits(pdf_side_a_t);
    localparam int SB_W = $bits(pdf_side_b_t);

    logic             en;
    logic [ALT_W-1:0] h_cl;
    pdf_side_a_t      sa_in;

    logic             e_vld;
    logic [E_W-1:0]   e_val;
    logic [SA_W-1:0]  e_side;

    logic             rm_vld_reg;
    logic [50:0]      rm_num_reg;
    pdf_side_a_t      rm_side_reg;

    logic             rho_vld;
    logic [RHO_W-1:0] rho_val;
    logic [SA_W-1:0]  rho_side_v;
    pdf_side_a_t      rho_side;
    pdf_side_b_t      sb_in;

    logic              rt_vld;
    logic [ROOT_W-1:0] rt_val;
    logic [SB_W-1:0]   rt_side_v;

    logic             c_vld_reg;
    logic [C_W-1:0]   c_reg;
    pdf_side_b_t      c_side_reg;
    logic [41:0]      c_rnd;

    logic              mach_vld;
    logic [MACH_W-1:0] mach_val;
    logic [SB_W-1:0]   mach_side_v;

    logic             tail_vld;

    // Temperature drop over the clamped altitude, in 0.5 mK units.
    function automatic logic [T2_W-1:0] lapse_drop(input logic [ALT_W-1:0] h);
        return T2_W'(h) * T2_LAPSE;
    endfunction

    // Every stage advances together unless a finished result is held.
    assign en      = !tail_vld || m_ready;
    assign s_ready = en;
    assign m_valid = tail_vld;

    // Altitude clamp and linear temperature lapse.
    always_comb begin
        h_cl = (s_data.altitude > ALT_LIMIT) ? ALT_LIMIT : s_data.altitude;
        sa_in.speed       = s_data.speed;
        sa_in.diameter_mm = s_data.diameter_mm;
        sa_in.drag_scale  = s_data.drag_scale;
        sa_in.t2          = T2_SEA - lapse_drop(h_cl);
    end

    pdf_exp_pipe #(
        .SIDE_W (SA_W)
    ) u_exp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (s_valid),
        .h_i     (h_cl),
        .side_i  (sa_in),
        .vld_o   (e_vld),
        .e_o     (e_val),
        .side_o  (e_side)
    );

    // Density numerator.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rm_vld_reg <= 1'b0;
        end else if (en) begin
            rm_vld_reg <= e_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rm_num_reg  <= 51'(RHO_K) * 51'(e_val);
            rm_side_reg <= e_side;
        end
    end

    pdf_div_pipe #(
        .NUM_W  (51),
        .DEN_W  (T2_W),
        .QUO_W  (RHO_W),
        .SIDE_W (SA_W)
    ) u_rho_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (rm_vld_reg),
        .num_i   (rm_num_reg),
        .den_i   (rm_side_reg.t2),
        .side_i  (rm_side_reg),
        .vld_o   (rho_vld),
        .quo_o   (rho_val),
        .side_o  (rho_side_v)
    );

    always_comb begin
        rho_side          = rho_side_v;
        sb_in.speed       = rho_side.speed;
        sb_in.diameter_mm = rho_side.diameter_mm;
        sb_in.drag_scale  = rho_side.drag_scale;
        sb_in.rho         = rho_val;
    end

    pdf_isqrt_pipe #(
        .ROOT_W (ROOT_W),
        .SIDE_W (SB_W)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (rho_vld),
        .x_i     ({rho_side.t2, 32'd0}),
        .side_i  (sb_in),
        .vld_o   (rt_vld),
        .root_o  (rt_val),
        .side_o  (rt_side_v)
    );

    // Speed of sound from the temperature root.
    assign c_rnd = 42'(rt_val) * 42'(SOUND_K) + 42'd32768;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= rt_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg      <= c_rnd[40:16];
            c_side_reg <= rt_side_v;
        end
    end

    pdf_div_pipe #(
        .NUM_W  (43),
        .DEN_W  (C_W),
        .QUO_W  (MACH_W),
        .SIDE_W (SB_W)
    ) u_mach_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (c_vld_reg),
        .num_i   ({c_side_reg.speed, 28'd0}),
        .den_i   (c_reg),
        .side_i  (c_side_reg),
        .vld_o   (mach_vld),
        .quo_o   (mach_val),
        .side_o  (mach_side_v)
    );

    pdf_drag_tail u_tail (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (mach_vld),
        .mach_i  (mach_val),
        .side_i  (mach_side_v),
        .vld_o   (tail_vld),
        .res_o   (m_data)
    );

endmodule
